// ===== hdl/las_pkg.sv =====
// Shared types and constants for the least-attained-service scheduler.
// Used by las_alu, las_mem and least_attained_service_scheduler_top.
`timescale 1ns / 1ps

package las_pkg;

  // default number of process slots
  localparam int MAX_PROCS_DEF = 16;

  // field widths
  localparam int TIME_W = 32;
  localparam int VAL_W  = 16;
  localparam int CNT_W  = 5;
  localparam int ID_W   = 5;
  localparam int SLOT_W = 4;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // one process slot as held in the slot memory
  typedef struct packed {
    logic [VAL_W-1:0] arrival;
    logic [VAL_W-1:0] burst;
    logic [VAL_W-1:0] remaining;
    logic [VAL_W-1:0] service;
  } las_entry_t;

  // result of the shared subtract/compare unit
  typedef struct packed {
    logic              lt;
    logic [TIME_W-1:0] diff;
  } las_alu_res_t;

endpackage

// ===== hdl/least_attained_service_scheduler_top.sv =====
// Top level of the least-attained-service scheduler: sequencer and state.
// Depends on las_pkg, las_alu and las_mem.
//
//  channel | direction | ports                                   | handshake
//  in      | input     | in_operation, in_slot, in_arrival, in_burst | in_valid / in_stall
//  out     | output    | out_now .. out_all_done                 | out_valid / out_stall
//  cfg     | input     | cfg_wr_data (process count)             | cfg_wr_en
//
// A load writes its slot and goes to its result. A tick scans the slots in use for
// the least-served ready slot, then serves it; on a completion it also works out
// turnaround and waiting. The first effective tick first scans for the least arrival.
// The single read port of the slot memory means one slot is examined per cycle. A tick
// with everything done skips the scans. rst_n is synchronous; after reset process_count is 1.
// One transaction is in work at a time; the next is taken while a result waits
// on out_stall, and a finished result holds until the output register frees.
`timescale 1ns / 1ps

module least_attained_service_scheduler_top #(
  parameter int MAX_PROCS = las_pkg::MAX_PROCS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_operation,
  input  logic [las_pkg::SLOT_W-1:0]   in_slot,
  input  logic [las_pkg::VAL_W-1:0]    in_arrival,
  input  logic [las_pkg::VAL_W-1:0]    in_burst,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [las_pkg::TIME_W-1:0]   out_now,
  output logic [las_pkg::ID_W-1:0]     out_served_id,
  output logic                         out_finished,
  output logic [las_pkg::TIME_W-1:0]   out_turnaround,
  output logic [las_pkg::TIME_W-1:0]   out_waiting,
  output logic [las_pkg::TIME_W-1:0]   out_idle_total,
  output logic                         out_all_done,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [las_pkg::CNT_W-1:0]    cfg_wr_data
);

  localparam int AW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int TW = las_pkg::TIME_W;
  localparam int VW = las_pkg::VAL_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MIN  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_TA   = 3'd4;
  localparam logic [2:0] S_WT   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // control registers
  logic [2:0]              state_r, state_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic                    pend_r, pend_nxt;
  logic [las_pkg::CNT_W-1:0] pc_r, pc_nxt;
  logic [TW-1:0]           time_r, time_nxt;
  logic [TW-1:0]           idle_r, idle_nxt;
  logic                    started_r, started_nxt;
  logic [MAX_PROCS-1:0]    done_r, done_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // working registers
  logic [AW-1:0]           didx_r, didx_nxt;
  logic [TW-1:0]           min_r, min_nxt;
  logic                    found_r, found_nxt;
  logic [AW-1:0]           best_r, best_nxt;
  las_pkg::las_entry_t     best_e_r, best_e_nxt;
  logic [las_pkg::ID_W-1:0] served_r, served_nxt;
  logic                    fin_r, fin_nxt;
  logic [TW-1:0]           ta_r, ta_nxt;
  logic [TW-1:0]           wt_r, wt_nxt;

  // output payload registers
  logic [TW-1:0]           o_now_r, o_now_nxt;
  logic [las_pkg::ID_W-1:0] o_srv_r, o_srv_nxt;
  logic                    o_fin_r, o_fin_nxt;
  logic [TW-1:0]           o_ta_r, o_ta_nxt;
  logic [TW-1:0]           o_wt_r, o_wt_nxt;
  logic [TW-1:0]           o_idle_r, o_idle_nxt;
  logic                    o_all_r, o_all_nxt;

  // memory and ALU connections
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  las_pkg::las_entry_t     mem_wdata;
  las_pkg::las_entry_t     rd_e;
  logic [TW-1:0]           alu_a, alu_b;
  las_pkg::las_alu_res_t   alu_res;

  logic [CW-1:0]           n_w;
  logic [MAX_PROCS-1:0]    in_use;
  logic                    all_done_w;
  logic                    accept_w;
  logic                    last_w;
  logic                    ready_w;
  logic                    out_free_w;
  las_pkg::las_entry_t     upd_e;

  las_mem #(
    .DEPTH (MAX_PROCS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_e)
  );

  las_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  // slots in use, saturated to the slot count
  always_comb begin
    if (32'(pc_r) > 32'(MAX_PROCS)) begin
      n_w = CW'(MAX_PROCS);
    end else begin
      n_w = CW'(pc_r);
    end
  end

  // every slot in use is done
  always_comb begin
    for (int i = 0; i < MAX_PROCS; i++) begin
      in_use[i] = 32'(i) < 32'(n_w);
    end
    all_done_w = &(done_r | ~in_use);
  end

  assign accept_w   = in_valid && !in_stall;
  assign in_stall   = (state_r != S_IDLE);
  assign last_w     = (idx_r == n_w) && pend_r;
  assign out_free_w = !out_valid_r || !out_stall;

  // ready slot: arrived and not done
  assign ready_w = !done_r[didx_r] && ({{(TW-VW){1'b0}}, rd_e.arrival} <= time_r);

  // served slot after one unit
  always_comb begin
    upd_e = best_e_r;
    if (best_e_r.service != '1) begin
      upd_e.service = best_e_r.service + 1'b1;
    end
    if (best_e_r.remaining != '0) begin
      upd_e.remaining = best_e_r.remaining - 1'b1;
    end
  end

  // operand select for the shared unit
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state_r)
      S_MIN: begin
        alu_a = {{(TW-VW){1'b0}}, rd_e.arrival};
        alu_b = min_r;
      end
      S_SCAN: begin
        alu_a = {{(TW-VW){1'b0}}, rd_e.service};
        alu_b = {{(TW-VW){1'b0}}, best_e_r.service};
      end
      S_TA: begin
        alu_a = time_r;
        alu_b = {{(TW-VW){1'b0}}, best_e_r.arrival};
      end
      S_WT: begin
        alu_a = ta_r;
        alu_b = {{(TW-VW){1'b0}}, best_e_r.burst};
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pc_nxt        = pc_r;
    time_nxt      = time_r;
    idle_nxt      = idle_r;
    started_nxt   = started_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r;
    didx_nxt      = didx_r;
    min_nxt       = min_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_e_nxt    = best_e_r;
    served_nxt    = served_r;
    fin_nxt       = fin_r;
    ta_nxt        = ta_r;
    wt_nxt        = wt_r;
    o_now_nxt     = o_now_r;
    o_srv_nxt     = o_srv_r;
    o_fin_nxt     = o_fin_r;
    o_ta_nxt      = o_ta_r;
    o_wt_nxt      = o_wt_r;
    o_idle_nxt    = o_idle_r;
    o_all_nxt     = o_all_r;
    mem_we        = 1'b0;
    mem_waddr     = best_r;
    mem_wdata     = upd_e;

    if (cfg_wr_en) begin
      pc_nxt = cfg_wr_data;
    end

    // output register drains
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // pipelined slot walk: read issued at idx, data for didx in the next cycle
    if (state_r == S_MIN || state_r == S_SCAN) begin
      if (idx_r < n_w) begin
        idx_nxt  = idx_r + 1'b1;
        pend_nxt = 1'b1;
      end else begin
        pend_nxt = 1'b0;
      end
      didx_nxt = idx_r[AW-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept_w) begin
          served_nxt = '0;
          fin_nxt    = 1'b0;
          ta_nxt     = '0;
          wt_nxt     = '0;
          idx_nxt    = '0;
          pend_nxt   = 1'b0;
          found_nxt  = 1'b0;
          min_nxt    = '1;
          if (in_operation == las_pkg::OP_LOAD) begin
            if (32'(in_slot) < 32'(MAX_PROCS)) begin
              mem_we                 = 1'b1;
              mem_waddr              = AW'(in_slot);
              mem_wdata.arrival      = in_arrival;
              mem_wdata.burst        = in_burst;
              mem_wdata.remaining    = in_burst;
              mem_wdata.service      = '0;
              done_nxt[AW'(in_slot)] = 1'b0;
            end
            state_nxt = S_DONE;
          end else if (all_done_w) begin
            state_nxt = S_DONE;
          end else if (!started_r) begin
            state_nxt = S_MIN;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      // least arrival over the slots in use
      S_MIN: begin
        if (pend_r && alu_res.lt) begin
          min_nxt = alu_a;
        end
        if (last_w) begin
          time_nxt    = (pend_r && alu_res.lt) ? alu_a : min_r;
          started_nxt = 1'b1;
          idx_nxt     = '0;
          pend_nxt    = 1'b0;
          state_nxt   = S_SCAN;
        end
      end

      // least-served ready slot, lowest slot wins ties
      S_SCAN: begin
        if (pend_r && ready_w && (!found_r || alu_res.lt)) begin
          found_nxt  = 1'b1;
          best_nxt   = didx_r;
          best_e_nxt = rd_e;
        end
        if (last_w) begin
          state_nxt = S_UPD;
        end
      end

      // advance time, serve one unit
      S_UPD: begin
        time_nxt = (time_r == '1) ? time_r : time_r + 1'b1;
        if (!found_r) begin
          idle_nxt  = (idle_r == '1) ? idle_r : idle_r + 1'b1;
          state_nxt = S_DONE;
        end else begin
          mem_we     = 1'b1;
          best_e_nxt = upd_e;
          served_nxt = las_pkg::ID_W'({1'b0, best_r} + 1'b1);
          if (upd_e.remaining == '0) begin
            done_nxt[best_r] = 1'b1;
            fin_nxt          = 1'b1;
            state_nxt        = S_TA;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      // turnaround = completion time - arrival
      S_TA: begin
        ta_nxt    = alu_res.diff;
        state_nxt = S_WT;
      end

      // waiting = turnaround - burst, floored at zero
      S_WT: begin
        wt_nxt    = alu_res.lt ? '0 : alu_res.diff;
        state_nxt = S_DONE;
      end

      // hand the result to the output register
      S_DONE: begin
        if (out_free_w) begin
          out_valid_nxt = 1'b1;
          o_now_nxt     = time_r;
          o_srv_nxt     = served_r;
          o_fin_nxt     = fin_r;
          o_ta_nxt      = ta_r;
          o_wt_nxt      = wt_r;
          o_idle_nxt    = idle_r;
          o_all_nxt     = all_done_w;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      pc_r        <= las_pkg::CNT_W'(1);
      time_r      <= '0;
      idle_r      <= '0;
      started_r   <= 1'b0;
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      pc_r        <= pc_nxt;
      time_r      <= time_nxt;
      idle_r      <= idle_nxt;
      started_r   <= started_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    didx_r   <= didx_nxt;
    min_r    <= min_nxt;
    found_r  <= found_nxt;
    best_r   <= best_nxt;
    best_e_r <= best_e_nxt;
    served_r <= served_nxt;
    fin_r    <= fin_nxt;
    ta_r     <= ta_nxt;
    wt_r     <= wt_nxt;
    o_now_r  <= o_now_nxt;
    o_srv_r  <= o_srv_nxt;
    o_fin_r  <= o_fin_nxt;
    o_ta_r   <= o_ta_nxt;
    o_wt_r   <= o_wt_nxt;
    o_idle_r <= o_idle_nxt;
    o_all_r  <= o_all_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_now        = o_now_r;
  assign out_served_id  = o_srv_r;
  assign out_finished   = o_fin_r;
  assign out_turnaround = o_ta_r;
  assign out_waiting    = o_wt_r;
  assign out_idle_total = o_idle_r;
  assign out_all_done   = o_all_r;

endmodule

// ===== hdl/las_alu.sv =====
// Shared subtract/compare unit of the scheduler sequencer.
// Depends on las_pkg.
`timescale 1ns / 1ps

module las_alu (
  input  logic [las_pkg::TIME_W-1:0] a,
  input  logic [las_pkg::TIME_W-1:0] b,
  output las_pkg::las_alu_res_t      res
);

  logic [las_pkg::TIME_W:0] sub;

  // a - b with borrow out; borrow means a < b
  assign sub      = {1'b0, a} - {1'b0, b};
  assign res.lt   = sub[las_pkg::TIME_W];
  assign res.diff = sub[las_pkg::TIME_W-1:0];

endmodule

// ===== hdl/las_mem.sv =====
// Slot memory: one write port, one registered read port.
// Depends on las_pkg for the entry type.
`timescale 1ns / 1ps

module las_mem #(
  parameter int DEPTH = las_pkg::MAX_PROCS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  las_pkg::las_entry_t wr_data,
  input  logic [AW-1:0]       rd_addr,
  output las_pkg::las_entry_t rd_data
);

  las_pkg::las_entry_t mem [DEPTH];
  las_pkg::las_entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
